>>> rtl/rhsv_pkg.sv
// Shared widths, codes and the divider step for the RGB to HSV converter.
package rhsv_pkg;

   localparam int PIX_W          = 8;
   localparam int HUE_W          = 12;
   localparam int DIFF_W         = PIX_W + 1;
   localparam int DIV_W          = PIX_W + 1;
   localparam int REM_W          = 21;
   localparam int SAT_NUM_W      = 17;
   localparam int COEF_W         = 13;
   localparam int Q_W            = 12;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = Q_W / BITS_PER_STAGE;

   // Sector codes: which channel holds the maximum
   localparam logic [1:0] SECT_RED   = 2'd0;
   localparam logic [1:0] SECT_GREEN = 2'd1;
   localparam logic [1:0] SECT_BLUE  = 2'd2;

   // Hue numerator is 2*num + delta = 1200*diff + coef*delta
   localparam logic signed [REM_W+1:0] HUE_DIFF_MUL = 1200;
   localparam logic [COEF_W-1:0] COEF_RED_POS = 13'd1;
   localparam logic [COEF_W-1:0] COEF_RED_NEG = 13'd7201;
   localparam logic [COEF_W-1:0] COEF_GREEN   = 13'd2401;
   localparam logic [COEF_W-1:0] COEF_BLUE    = 13'd4801;

   localparam logic [SAT_NUM_W-1:0] SAT_MUL  = 17'd510;
   localparam logic [HUE_W-1:0]     HUE_FULL = 12'd3600;

   typedef struct packed {
      logic [REM_W-1:0]          rem;
      logic [BITS_PER_STAGE-1:0] qbits;
   } div_step_type;

   // Restoring division, BITS_PER_STAGE quotient bits starting at top_bit
   function automatic div_step_type div_step(input logic [REM_W-1:0] rem,
                                             input logic [DIV_W-1:0] dvs,
                                             input int top_bit);
      div_step_type res;
      logic [REM_W-1:0] r;
      logic [REM_W-1:0] trial;
      r         = rem;
      res.qbits = '0;
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
         trial = REM_W'(dvs) << (top_bit - k);
         if (r >= trial) begin
            r = r - trial;
            res.qbits[BITS_PER_STAGE-1-k] = 1'b1;
         end
      end
      res.rem = r;
      return res;
   endfunction

endpackage

>>> rtl/rhsv_req_if.sv
// Pixel input channel: valid/ready with the three color channels.
interface rhsv_req_if;
   logic                      valid;
   logic                      ready;
   logic [rhsv_pkg::PIX_W-1:0] red;
   logic [rhsv_pkg::PIX_W-1:0] green;
   logic [rhsv_pkg::PIX_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/rhsv_rsp_if.sv
// HSV result channel: valid/ready with hue, saturation and brightness.
interface rhsv_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rhsv_pkg::HUE_W-1:0] hue_tenths;
   logic [rhsv_pkg::PIX_W-1:0] saturation;
   logic [rhsv_pkg::PIX_W-1:0] brightness;

   modport source (output valid, output hue_tenths, output saturation,
                   output brightness, input ready);
   modport sink   (input valid, input hue_tenths, input saturation,
                   input brightness, output ready);
endinterface

>>> rtl/rgb_to_hsv_converter_top.sv
// Pipelined RGB to HSV converter: min/max, numerators, radix-4 dividers, wrap.
// Stages: 2 prep stages, 6 divider stages of 2 quotient bits each, 1 output stage.
// Throughput: one pixel per cycle unless the sink stalls; the divider pipeline sets depth.
// A skid register on the output keeps results while the sink stalls.
// Synchronous active-high reset clears all valid bits and the skid flag.
module rgb_to_hsv_converter_top (
   input  logic              clock,
   input  logic              reset,
   rhsv_req_if.sink          req_if,
   rhsv_rsp_if.source        rsp_if
);

   localparam int NS = rhsv_pkg::DIV_STAGES;

   logic en;
   logic skid_full_ff, skid_full_in;

   assign en           = !skid_full_ff;
   assign req_if.ready = en;

   // ---------------- stage 1: max, min, sector, difference
   logic                                s1_valid_ff;
   logic [rhsv_pkg::PIX_W-1:0]          s1_mx_ff, s1_mx_in;
   logic [rhsv_pkg::PIX_W-1:0]          s1_delta_ff, s1_delta_in;
   logic [1:0]                          s1_sect_ff, s1_sect_in;
   logic signed [rhsv_pkg::DIFF_W-1:0]  s1_diff_ff, s1_diff_in;

   logic [rhsv_pkg::PIX_W-1:0] r_c, g_c, b_c, mn_c;

   always_comb begin
      r_c = req_if.red;
      g_c = req_if.green;
      b_c = req_if.blue;
      if (r_c >= g_c && r_c >= b_c) begin
         s1_sect_in = rhsv_pkg::SECT_RED;
         s1_mx_in   = r_c;
         s1_diff_in = $signed({1'b0, g_c}) - $signed({1'b0, b_c});
      end else if (g_c >= b_c) begin
         s1_sect_in = rhsv_pkg::SECT_GREEN;
         s1_mx_in   = g_c;
         s1_diff_in = $signed({1'b0, b_c}) - $signed({1'b0, r_c});
      end else begin
         s1_sect_in = rhsv_pkg::SECT_BLUE;
         s1_mx_in   = b_c;
         s1_diff_in = $signed({1'b0, r_c}) - $signed({1'b0, g_c});
      end
      mn_c = (r_c < g_c) ? r_c : g_c;
      mn_c = (mn_c < b_c) ? mn_c : b_c;
      s1_delta_in = s1_mx_in - mn_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_if.valid;
      end
      if (en) begin
         s1_mx_ff    <= s1_mx_in;
         s1_delta_ff <= s1_delta_in;
         s1_sect_ff  <= s1_sect_in;
         s1_diff_ff  <= s1_diff_in;
      end
   end

   // ---------------- stage 2: dividends and divisors
   logic                             dv_valid_ff [NS+1];
   logic                             dv_grey_ff  [NS+1];
   logic [rhsv_pkg::PIX_W-1:0]       dv_bright_ff[NS+1];
   logic [rhsv_pkg::REM_W-1:0]       dv_hrem_ff  [NS+1];
   logic [rhsv_pkg::REM_W-1:0]       dv_srem_ff  [NS+1];
   logic [rhsv_pkg::DIV_W-1:0]       dv_hdiv_ff  [NS+1];
   logic [rhsv_pkg::DIV_W-1:0]       dv_sdiv_ff  [NS+1];
   logic [rhsv_pkg::Q_W-1:0]         dv_hq_ff    [NS+1];
   logic [rhsv_pkg::Q_W-1:0]         dv_sq_ff    [NS+1];

   logic [rhsv_pkg::COEF_W-1:0]      coef_c;
   logic [rhsv_pkg::REM_W-1:0]       coef_delta_c;
   logic signed [rhsv_pkg::REM_W+1:0] hue_num_c;
   logic [rhsv_pkg::SAT_NUM_W-1:0]   sat_num_c;

   always_comb begin
      case (s1_sect_ff)
         rhsv_pkg::SECT_RED:   coef_c = s1_diff_ff[rhsv_pkg::DIFF_W-1] ?
                                        rhsv_pkg::COEF_RED_NEG : rhsv_pkg::COEF_RED_POS;
         rhsv_pkg::SECT_GREEN: coef_c = rhsv_pkg::COEF_GREEN;
         rhsv_pkg::SECT_BLUE:  coef_c = rhsv_pkg::COEF_BLUE;
         default:              coef_c = rhsv_pkg::COEF_RED_POS;
      endcase
      coef_delta_c = rhsv_pkg::REM_W'(coef_c) * rhsv_pkg::REM_W'(s1_delta_ff);
      // always non-negative once the sector offset is added
      hue_num_c = (rhsv_pkg::REM_W+2)'(s1_diff_ff) * rhsv_pkg::HUE_DIFF_MUL
                + $signed({2'd0, coef_delta_c});
      sat_num_c = rhsv_pkg::SAT_NUM_W'(s1_delta_ff) * rhsv_pkg::SAT_MUL
                + rhsv_pkg::SAT_NUM_W'(s1_mx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= s1_valid_ff;
      end
      if (en) begin
         dv_grey_ff[0]   <= (s1_delta_ff == '0);
         dv_bright_ff[0] <= s1_mx_ff;
         dv_hrem_ff[0]   <= hue_num_c[rhsv_pkg::REM_W-1:0];
         dv_srem_ff[0]   <= rhsv_pkg::REM_W'(sat_num_c);
         dv_hdiv_ff[0]   <= {s1_delta_ff, 1'b0};
         dv_sdiv_ff[0]   <= {s1_mx_ff, 1'b0};
         dv_hq_ff[0]     <= '0;
         dv_sq_ff[0]     <= '0;
      end
   end

   // ---------------- divider stages, two quotient bits each
   for (genvar j = 0; j < NS; j++) begin : g_div
      localparam int TOP = rhsv_pkg::Q_W - 1 - j * rhsv_pkg::BITS_PER_STAGE;
      rhsv_pkg::div_step_type hstep_c, sstep_c;

      always_comb begin
         hstep_c = rhsv_pkg::div_step(dv_hrem_ff[j], dv_hdiv_ff[j], TOP);
         sstep_c = rhsv_pkg::div_step(dv_srem_ff[j], dv_sdiv_ff[j], TOP);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
         if (en) begin
            dv_grey_ff[j+1]   <= dv_grey_ff[j];
            dv_bright_ff[j+1] <= dv_bright_ff[j];
            dv_hrem_ff[j+1]   <= hstep_c.rem;
            dv_srem_ff[j+1]   <= sstep_c.rem;
            dv_hdiv_ff[j+1]   <= dv_hdiv_ff[j];
            dv_sdiv_ff[j+1]   <= dv_sdiv_ff[j];
            dv_hq_ff[j+1]     <= {dv_hq_ff[j][rhsv_pkg::Q_W-rhsv_pkg::BITS_PER_STAGE-1:0],
                                  hstep_c.qbits};
            dv_sq_ff[j+1]     <= {dv_sq_ff[j][rhsv_pkg::Q_W-rhsv_pkg::BITS_PER_STAGE-1:0],
                                  sstep_c.qbits};
         end
      end
   end

   // ---------------- output stage: grey override and hue wrap
   logic                       out_valid_ff;
   logic [rhsv_pkg::HUE_W-1:0] out_hue_ff, out_hue_in;
   logic [rhsv_pkg::PIX_W-1:0] out_sat_ff, out_sat_in;
   logic [rhsv_pkg::PIX_W-1:0] out_bright_ff;

   always_comb begin
      if (dv_grey_ff[NS]) begin
         out_hue_in = '0;
         out_sat_in = '0;
      end else begin
         out_hue_in = (dv_hq_ff[NS] >= rhsv_pkg::HUE_FULL) ?
                      dv_hq_ff[NS] - rhsv_pkg::HUE_FULL : dv_hq_ff[NS];
         out_sat_in = dv_sq_ff[NS][rhsv_pkg::PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_valid_ff[NS];
      end
      if (en) begin
         out_hue_ff    <= out_hue_in;
         out_sat_ff    <= out_sat_in;
         out_bright_ff <= dv_bright_ff[NS];
      end
   end

   // ---------------- skid register: catches the head item when the sink stalls
   logic [rhsv_pkg::HUE_W-1:0] skid_hue_ff;
   logic [rhsv_pkg::PIX_W-1:0] skid_sat_ff;
   logic [rhsv_pkg::PIX_W-1:0] skid_bright_ff;

   always_comb begin
      skid_full_in = skid_full_ff;
      if (skid_full_ff) begin
         if (rsp_if.ready) begin
            skid_full_in = 1'b0;
         end
      end else if (out_valid_ff && !rsp_if.ready) begin
         skid_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
      end
      if (!skid_full_ff) begin
         skid_hue_ff    <= out_hue_ff;
         skid_sat_ff    <= out_sat_ff;
         skid_bright_ff <= out_bright_ff;
      end
   end

   assign rsp_if.valid      = skid_full_ff || out_valid_ff;
   assign rsp_if.hue_tenths = skid_full_ff ? skid_hue_ff    : out_hue_ff;
   assign rsp_if.saturation = skid_full_ff ? skid_sat_ff    : out_sat_ff;
   assign rsp_if.brightness = skid_full_ff ? skid_bright_ff : out_bright_ff;

endmodule
